@@ sv/scbp_pkg.sv @@
// Shared types and constants for the signed cents bracket parser.
// Holds the item and result payload structs and the character codes.
// No dependencies.
`default_nettype none

package scbp_pkg;

	localparam int unsigned LIMIT_W = 27;
	localparam int unsigned BOUND_W = 28;
	localparam int unsigned PROD_W  = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 27'd10000;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_OPEN   = 8'h5B;
	localparam logic [7:0] CH_CLOSE  = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} item_t;

	typedef struct packed {
		logic                      accepted;
		logic                      bracket_set;
		logic signed [BOUND_W-1:0] low_bound_cents;
		logic signed [BOUND_W-1:0] high_bound_cents;
	} result_t;

endpackage

`default_nettype wire

@@ sv/signed_cents_bracket_parser_unit.sv @@
// Signed cents bracket parser: scans a character stream for "+[lo,hi]" and
// emits one result per payload. Depends on scbp_pkg.
//
// A result is registered as its last character leaves the input register.
// Throughput: one character per cycle unless a last character waits on a stalled result.
// A last character waits in the input register only while an earlier result is stalled.
// Reset (arst_n low) clears the parse state, empties both registers, limit = 10000.
`default_nettype none

module signed_cents_bracket_parser_unit
	import scbp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire item_t               item,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output result_t                  result,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [LIMIT_W-1:0]  cfg_data
);

	typedef enum logic [2:0] {
		SP_SEEK = 3'd0,
		SP_PLUS = 3'd1,
		SP_LOW  = 3'd2,
		SP_HIGH = 3'd3,
		SP_DONE = 3'd4
	} scan_t;

	typedef enum logic [2:0] {
		FP_LEAD  = 3'd0,
		FP_SIGN  = 3'd1,
		FP_INT   = 3'd2,
		FP_FRAC1 = 3'd3,
		FP_FRAC2 = 3'd4,
		FP_END   = 3'd5,
		FP_TRAIL = 3'd6
	} field_t;

	logic [LIMIT_W-1:0]        limit_q;

	logic                      valid_s1;
	item_t                     item_s1;
	logic                      valid_s2;
	result_t                   result_s2;

	scan_t                     scan_q, scan_n;
	field_t                    field_q, field_n;
	logic                      neg_q, neg_n;
	logic [BOUND_W-1:0]        mag_q, mag_n;
	logic                      ovf_q, ovf_n;
	logic signed [BOUND_W-1:0] low_q, low_n;
	logic                      err_q, err_n;

	logic                      advance;
	logic                      emit;
	logic [7:0]                c;
	logic                      c_space;
	logic                      c_digit;
	logic                      field_step;
	logic                      cur_ok;
	logic signed [BOUND_W-1:0] cur_val;
	logic signed [BOUND_W-1:0] end_val;
	logic [BOUND_W-1:0]        limit_p1;
	result_t                   res_n;

	assign cfg_ready = 1'b1;

	// a last character needs the result register free or draining
	assign advance    = !(valid_s1 && item_s1.last_char && valid_s2 && result_stall);
	assign item_stall = valid_s1 && !advance;
	assign emit       = valid_s1 && advance && item_s1.last_char;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	assign c        = item_s1.char_code;
	assign c_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	assign c_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
	assign limit_p1 = {1'b0, limit_q} + {{(BOUND_W-1){1'b0}}, 1'b1};

	// next parse state; magnitude * 10 + digit, as two shifts and two adds
	always_comb begin
		logic [PROD_W-1:0] m10;
		m10 = ({{(PROD_W-BOUND_W){1'b0}}, mag_q} << 3)
			+ ({{(PROD_W-BOUND_W){1'b0}}, mag_q} << 1)
			+ {{(PROD_W-4){1'b0}}, c[3:0]};
		cur_ok  = ((field_q == FP_END) || (field_q == FP_TRAIL)) && !ovf_q;
		cur_val = neg_q ? -$signed({1'b0, mag_q[LIMIT_W-1:0]})
				: $signed({1'b0, mag_q[LIMIT_W-1:0]});

		scan_n     = scan_q;
		field_n    = field_q;
		neg_n      = neg_q;
		mag_n      = mag_q;
		ovf_n      = ovf_q;
		low_n      = low_q;
		err_n      = err_q;
		field_step = 1'b0;

		case (scan_q)
			SP_PLUS: begin
				if (c == CH_OPEN) begin
					field_n = FP_LEAD;
					neg_n   = 1'b0;
					mag_n   = '0;
					ovf_n   = 1'b0;
					scan_n  = SP_LOW;
				end else if (c != CH_PLUS) begin
					scan_n = SP_SEEK;
				end
			end
			SP_LOW: begin
				if (c == CH_COMMA) begin
					if (cur_ok) low_n = cur_val;
					else        err_n = 1'b1;
					field_n = FP_LEAD;
					neg_n   = 1'b0;
					mag_n   = '0;
					ovf_n   = 1'b0;
					scan_n  = SP_HIGH;
				end else if (c == CH_CLOSE) begin
					err_n  = 1'b1;
					scan_n = SP_DONE;
				end else begin
					field_step = 1'b1;
				end
			end
			SP_HIGH: begin
				if (c == CH_CLOSE) begin
					if (!cur_ok || (low_q > cur_val)) err_n = 1'b1;
					scan_n = SP_DONE;
				end else begin
					field_step = 1'b1;
				end
			end
			SP_DONE: begin
			end
			default: begin
				scan_n = (c == CH_PLUS) ? SP_PLUS : SP_SEEK;
			end
		endcase

		if (field_step) begin
			case (field_q)
				FP_LEAD: begin
					if ((c == CH_PLUS) || (c == CH_MINUS)) begin
						neg_n   = (c == CH_MINUS);
						field_n = FP_SIGN;
					end else if (!c_space) begin
						err_n = 1'b1;
					end
				end
				FP_SIGN, FP_INT, FP_FRAC1, FP_FRAC2: begin
					if (c_digit) begin
						if (m10 > {{(PROD_W-LIMIT_W){1'b0}}, limit_q}) begin
							ovf_n = 1'b1;
							mag_n = limit_p1;
						end else begin
							mag_n = m10[BOUND_W-1:0];
						end
						case (field_q)
							FP_SIGN:  field_n = FP_INT;
							FP_FRAC1: field_n = FP_FRAC2;
							FP_FRAC2: field_n = FP_END;
							default:  field_n = field_q;
						endcase
					end else if ((field_q == FP_INT) && (c == CH_POINT)) begin
						field_n = FP_FRAC1;
					end else begin
						err_n = 1'b1;
					end
				end
				FP_END, FP_TRAIL: begin
					if (c_space) field_n = FP_TRAIL;
					else         err_n   = 1'b1;
				end
				default: begin
					err_n = 1'b1;
				end
			endcase
		end

		end_val = neg_n ? -$signed({1'b0, mag_n[LIMIT_W-1:0]})
				: $signed({1'b0, mag_n[LIMIT_W-1:0]});

		res_n.accepted         = 1'b0;
		res_n.bracket_set      = 1'b0;
		res_n.low_bound_cents  = '0;
		res_n.high_bound_cents = '0;
		case (scan_n)
			SP_LOW, SP_HIGH: begin
				res_n.accepted = 1'b0;
			end
			SP_DONE: begin
				if (!err_n) begin
					res_n.accepted = 1'b1;
					if ((low_n != '0) || (end_val != '0)) begin
						res_n.bracket_set      = 1'b1;
						res_n.low_bound_cents  = low_n;
						res_n.high_bound_cents = end_val;
					end
				end
			end
			default: begin
				res_n.accepted = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= LIMIT_RESET;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			scan_q   <= SP_SEEK;
			field_q  <= FP_LEAD;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			ovf_q    <= 1'b0;
			low_q    <= '0;
			err_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) limit_q <= cfg_data;

			if (item_valid && !item_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (emit) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end

			if (valid_s1 && advance) begin
				if (item_s1.last_char) begin
					// payload finished: parse state back to its start
					scan_q  <= SP_SEEK;
					field_q <= FP_LEAD;
					neg_q   <= 1'b0;
					mag_q   <= '0;
					ovf_q   <= 1'b0;
					low_q   <= '0;
					err_q   <= 1'b0;
				end else begin
					scan_q  <= scan_n;
					field_q <= field_n;
					neg_q   <= neg_n;
					mag_q   <= mag_n;
					ovf_q   <= ovf_n;
					low_q   <= low_n;
					err_q   <= err_n;
				end
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) item_s1 <= item;
		if (emit) result_s2 <= res_n;
	end

endmodule

`default_nettype wire
